FILE: hw/rtl/scaled_offset_codec_macros.svh
// Assertion macros shared by the scaled offset codec RTL.
`ifndef SCALED_OFFSET_CODEC_MACROS_SVH
`define SCALED_OFFSET_CODEC_MACROS_SVH

// Check a property at every clock edge outside reset.
`define SOC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("scaled offset codec: assertion failed");

// Check a property at every clock edge, reset included.
`define SOC_ASSERT_ANY(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("scaled offset codec: assertion failed");

`endif

FILE: hw/rtl/soc_pkg.sv
// Package with types and constants of the scaled offset codec.
`timescale 1ns / 1ps

package soc_pkg;

  localparam int unsigned VALUE_W    = 64;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned MANT_W     = 28;
  localparam int unsigned EXP_W      = 4;
  localparam int unsigned BASE_SHIFT = 8;
  localparam int unsigned MAX_EXP    = 15;
  localparam int unsigned SHIFT_W    = 5;
  localparam int unsigned NEED_W     = 5;

  typedef enum logic [1:0] {
    OP_DECODE = 2'd0,
    OP_ENCODE = 2'd1,
    OP_ROUND  = 2'd2
  } soc_op_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [VALUE_W-1:0] offset_value;
    logic [WORD_W-1:0]  offset_word;
  } soc_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] result_value;
    logic [WORD_W-1:0]  result_word;
    logic               too_big;
  } soc_res_t;

endpackage

FILE: hw/rtl/soc_in_if.sv
// Request channel interface of the scaled offset codec.
`timescale 1ns / 1ps

interface soc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [63:0] offset_value;
  logic [31:0] offset_word;

  modport source (output valid, operation, offset_value, offset_word, input ready);
  modport sink   (input valid, operation, offset_value, offset_word, output ready);
endinterface

FILE: hw/rtl/soc_out_if.sv
// Result channel interface of the scaled offset codec.
`timescale 1ns / 1ps

interface soc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic [31:0] result_word;
  logic        too_big;

  modport source (output valid, result_value, result_word, too_big, input ready);
  modport sink   (input valid, result_value, result_word, too_big, output ready);
endinterface

FILE: hw/rtl/scaled_offset_codec.sv
// Top level of the scaled offset codec: input stage, datapath, result stage.
// An accepted input lands in the input register (s1); its result is then taken into
// the result register once the result stage advances, so a result stall can delay it.
// Throughput: one item per cycle while out_o.ready holds; the leading-one detect
// and shifters sit between the input register and the result register.
// A stalled result holds while the input stage keeps one more item.
// Reset (rst_ni low, asynchronous) clears both valid flags; payload is not reset.
`timescale 1ns / 1ps
`include "scaled_offset_codec_macros.svh"

module scaled_offset_codec (
  input  logic      clk_i,
  input  logic      rst_ni,
  soc_in_if.sink    in_i,
  soc_out_if.source out_o
);

  logic              s1_valid_q, s1_valid_d;
  soc_pkg::soc_req_t s1_req_q;
  logic              out_valid_q, out_valid_d;
  soc_pkg::soc_res_t out_res_q;
  soc_pkg::soc_res_t core_res;
  logic              s1_adv;
  logic              in_xfer;

  assign s1_adv   = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_comb begin
    s1_valid_d  = in_i.ready ? in_i.valid : s1_valid_q;
    out_valid_d = s1_adv ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_req_q.operation    <= in_i.operation;
      s1_req_q.offset_value <= in_i.offset_value;
      s1_req_q.offset_word  <= in_i.offset_word;
    end
    if (s1_valid_q && s1_adv) begin
      out_res_q <= core_res;
    end
  end

  soc_core u_core (
    .req_i (s1_req_q),
    .res_o (core_res)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = out_res_q.result_value;
  assign out_o.result_word  = out_res_q.result_word;
  assign out_o.too_big      = out_res_q.too_big;

  `SOC_ASSERT_ANY(a_reset_empty, clk_i, !rst_ni |=> (!s1_valid_q && !out_valid_q))
  `SOC_ASSERT_CLK(a_in_lands, clk_i, rst_ni, in_xfer |=> s1_valid_q)
  `SOC_ASSERT_CLK(a_s1_moves, clk_i, rst_ni, (s1_valid_q && s1_adv) |=> out_valid_q)
  `SOC_ASSERT_CLK(a_err_zero, clk_i, rst_ni,
    (out_valid_q && out_res_q.too_big) |->
      (out_res_q.result_value == '0 && out_res_q.result_word == '0))

endmodule

FILE: hw/rtl/soc_core.sv
// Combinational decode, encode and round-up datapath.
`timescale 1ns / 1ps

module soc_core (
  input  soc_pkg::soc_req_t req_i,
  output soc_pkg::soc_res_t res_o
);

  localparam int unsigned VW   = soc_pkg::VALUE_W;
  localparam int unsigned MW   = soc_pkg::MANT_W;
  localparam int unsigned EW   = soc_pkg::EXP_W;
  localparam int unsigned FW   = VW - soc_pkg::BASE_SHIFT;
  localparam int unsigned HI_W = FW - MW;
  localparam int unsigned SW   = soc_pkg::SHIFT_W;
  localparam int unsigned NW   = soc_pkg::NEED_W;

  logic [FW-1:0]   mant_full;
  logic [NW-1:0]   exp_need;
  logic [FW-1:0]   mant_sh;
  logic [MW-1:0]   mant;
  logic            fits;
  logic [EW-1:0]   expo;
  logic [SW-1:0]   shift;
  logic [VW-1:0]   low_mask;
  logic            exact;
  logic [VW-1:0]   trunc_val;
  logic [MW:0]     mant_inc;
  logic [VW-1:0]   bump_val;
  logic [VW-1:0]   carry_val;
  logic [EW-1:0]   dec_exp;
  logic [VW-1:0]   dec_val;
  logic [VW-1:0]   round_val;
  logic            round_err;

  assign mant_full = req_i.offset_value[VW-1:soc_pkg::BASE_SHIFT];

  always_comb begin
    exp_need = '0;
    for (int i = 0; i < int'(HI_W); i++) begin
      if (mant_full[MW+i]) begin
        exp_need = NW'(i + 1);
      end
    end
  end

  assign mant_sh   = mant_full >> exp_need;
  assign mant      = mant_sh[MW-1:0];
  assign fits      = (exp_need <= NW'(soc_pkg::MAX_EXP));
  assign expo      = exp_need[EW-1:0];
  assign shift     = SW'(expo) + SW'(soc_pkg::BASE_SHIFT);
  assign low_mask  = (VW'(1) << shift) - VW'(1);
  assign exact     = ((req_i.offset_value & low_mask) == '0);
  assign trunc_val = VW'(mant) << shift;
  assign mant_inc  = (MW+1)'(mant) + (MW+1)'(1);
  assign bump_val  = VW'(mant_inc[MW-1:0]) << shift;
  assign carry_val = VW'(1) << ((SW+1)'(shift) + (SW+1)'(MW));

  always_comb begin
    round_val = '0;
    round_err = 1'b0;
    priority if (!fits) begin
      round_err = 1'b1;
    end else if (exact) begin
      round_val = trunc_val;
    end else if (!mant_inc[MW]) begin
      round_val = bump_val;
    end else if (expo == EW'(soc_pkg::MAX_EXP)) begin
      round_err = 1'b1;
    end else begin
      round_val = carry_val;
    end
  end

  assign dec_exp = req_i.offset_word[soc_pkg::WORD_W-1 -: EW];
  assign dec_val = VW'(req_i.offset_word[MW-1:0])
                   << (SW'(dec_exp) + SW'(soc_pkg::BASE_SHIFT));

  always_comb begin
    res_o = '0;
    unique case (soc_pkg::soc_op_e'(req_i.operation))
      soc_pkg::OP_DECODE: res_o.result_value = dec_val;
      soc_pkg::OP_ENCODE: begin
        res_o.too_big = !fits;
        if (fits) begin
          res_o.result_word = {expo, mant};
        end
      end
      soc_pkg::OP_ROUND: begin
        res_o.result_value = round_val;
        res_o.too_big      = round_err;
      end
      default: res_o = '0;
    endcase
  end

endmodule

FILE: bench/tb_scaled_offset_codec.sv
// Self-checking testbench for the scaled offset codec with random handshake stalls.
`timescale 1ns / 1ps

module tb_scaled_offset_codec;

  localparam int unsigned CLK_PERIOD  = 20;
  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned MAX_IDLE    = 17;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned MAX_SHIFT   = soc_pkg::BASE_SHIFT + soc_pkg::MAX_EXP;
  localparam logic [63:0] MANT_LIMIT  = 64'h0fff_ffff;
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned NUM_ROWS    = 24;

  typedef struct packed {
    logic [1:0]        op;
    logic [63:0]       value;
    logic [31:0]       word;
    logic              typed;
    soc_pkg::soc_res_t golden;
  } codec_row_t;

  localparam soc_pkg::soc_res_t NO_RES  = '{64'h0, 32'h0, 1'b0};
  localparam soc_pkg::soc_res_t TOO_BIG = '{64'h0, 32'h0, 1'b1};

  localparam codec_row_t CODEC_ROWS [NUM_ROWS] = '{
    '{soc_pkg::OP_DECODE, 64'h0, 32'h0000_0000, 1'b1, NO_RES},
    '{soc_pkg::OP_DECODE, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1,
      '{64'h0007_ffff_ff80_0000, 32'h0, 1'b0}},
    '{soc_pkg::OP_DECODE, 64'h0, 32'h0000_0001, 1'b1, '{64'h100, 32'h0, 1'b0}},
    '{soc_pkg::OP_DECODE, 64'h0, 32'hf000_0001, 1'b1, '{64'h80_0000, 32'h0, 1'b0}},
    '{soc_pkg::OP_DECODE, 64'h0, 32'h0fff_ffff, 1'b1, '{64'hf_ffff_ff00, 32'h0, 1'b0}},
    '{soc_pkg::OP_DECODE, 64'h0, 32'h5a5a_5a5a, 1'b0, NO_RES},
    '{soc_pkg::OP_ENCODE, 64'h0, 32'hffff_ffff, 1'b1, NO_RES},
    '{soc_pkg::OP_ENCODE, 64'hff, 32'h0, 1'b1, NO_RES},
    '{soc_pkg::OP_ENCODE, 64'h100, 32'h0, 1'b1, '{64'h0, 32'h0000_0001, 1'b0}},
    '{soc_pkg::OP_ENCODE, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1, TOO_BIG},
    '{soc_pkg::OP_ENCODE, 64'h0007_ffff_ff80_0000, 32'h0, 1'b1,
      '{64'h0, 32'hffff_ffff, 1'b0}},
    '{soc_pkg::OP_ENCODE, 64'h0008_0000_0000_0000, 32'h0, 1'b1, TOO_BIG},
    '{soc_pkg::OP_ENCODE, 64'h0000_0012_3456_789a, 32'h0, 1'b0, NO_RES},
    '{soc_pkg::OP_ENCODE, 64'h0000_000f_ffff_ffff, 32'h0, 1'b0, NO_RES},
    '{soc_pkg::OP_ROUND, 64'h0, 32'hffff_ffff, 1'b1, NO_RES},
    '{soc_pkg::OP_ROUND, 64'h1, 32'h0, 1'b1, '{64'h100, 32'h0, 1'b0}},
    '{soc_pkg::OP_ROUND, 64'h100, 32'h0, 1'b1, '{64'h100, 32'h0, 1'b0}},
    '{soc_pkg::OP_ROUND, 64'h0007_ffff_ff80_0000, 32'h0, 1'b1,
      '{64'h0007_ffff_ff80_0000, 32'h0, 1'b0}},
    '{soc_pkg::OP_ROUND, 64'h0007_ffff_ff80_0001, 32'h0, 1'b1, TOO_BIG},
    '{soc_pkg::OP_ROUND, 64'hffff_ffff_ffff_ffff, 32'h0, 1'b1, TOO_BIG},
    '{soc_pkg::OP_ROUND, 64'h0000_000f_ffff_ff01, 32'h0, 1'b0, NO_RES},
    '{soc_pkg::OP_ROUND, 64'h0000_00ff_ffff_ffff, 32'h0, 1'b0, NO_RES},
    '{OP_UNUSED, 64'hffff_ffff_ffff_ffff, 32'hffff_ffff, 1'b1, NO_RES},
    '{OP_UNUSED, 64'h0, 32'h0, 1'b1, NO_RES}
  };

  logic clk_i;
  logic rst_ni;

  soc_in_if  in_ch ();
  soc_out_if out_ch ();

  scaled_offset_codec dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  soc_pkg::soc_res_t pending_results [$];
  int unsigned       mismatch_count = 0;
  bit                sender_idles   = 1'b0;
  bit                sink_idles     = 1'b0;

  initial clk_i = 1'b0;
  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic soc_pkg::soc_res_t predict_codec_result(logic [1:0] op,
                                                             logic [63:0] value,
                                                             logic [31:0] word);
    soc_pkg::soc_res_t res;
    logic [63:0]       mant;
    int unsigned       shift;
    bit                done;
    res  = '0;
    mant = value >> soc_pkg::BASE_SHIFT;
    case (op)
      soc_pkg::OP_DECODE: begin
        res.result_value = {36'd0, word[27:0]} << (word[31:28] + soc_pkg::BASE_SHIFT);
      end
      soc_pkg::OP_ENCODE: begin
        shift = 0;
        while (mant > MANT_LIMIT) begin
          shift++;
          mant >>= 1;
        end
        if (shift > soc_pkg::MAX_EXP) begin
          res.too_big = 1'b1;
        end else begin
          res.result_word = {shift[3:0], mant[27:0]};
        end
      end
      soc_pkg::OP_ROUND: begin
        shift = soc_pkg::BASE_SHIFT;
        while (mant > MANT_LIMIT) begin
          shift++;
          mant >>= 1;
        end
        done = 1'b0;
        while (!done) begin
          if (shift > MAX_SHIFT) begin
            res.too_big = 1'b1;
            done = 1'b1;
          end else if ((mant << shift) >= value) begin
            res.result_value = mant << shift;
            done = 1'b1;
          end else begin
            mant++;
            if (mant <= MANT_LIMIT) begin
              res.result_value = mant << shift;
              done = 1'b1;
            end else begin
              shift++;
              mant >>= 1;
            end
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  function automatic logic [63:0] random_offset();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v;
      1: v = v >> $urandom_range(0, 63);
      2: v = (64'd1 << $urandom_range(0, 63)) + 64'($urandom_range(0, 2)) - 64'd1;
      3: v = ({36'd0, v[27:0]} << $urandom_range(soc_pkg::BASE_SHIFT, MAX_SHIFT))
             + 64'($urandom_range(0, 2)) - 64'd1;
      4: v = ({36'd0, MANT_LIMIT[27:0]} << $urandom_range(soc_pkg::BASE_SHIFT, MAX_SHIFT))
             + 64'($urandom_range(0, 300));
      default: v = v >> 24;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns mismatch %s: got %h want %h", $time, what, got, want);
    mismatch_count++;
  endtask

  // Send one request; returns at the edge where the transfer happens.
  task automatic send_request(logic [1:0] op, logic [63:0] value, logic [31:0] word,
                              bit typed, soc_pkg::soc_res_t golden);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= op;
    in_ch.offset_value <= value;
    in_ch.offset_word  <= word;
    do @(posedge clk_i); while (!in_ch.ready);
    pending_results.push_back(typed ? golden : predict_codec_result(op, value, word));
  endtask

  task automatic drain_pending();
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    rst_ni             = 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.operation    <= soc_pkg::OP_DECODE;
    in_ch.offset_value <= '0;
    in_ch.offset_word  <= '0;
    out_ch.ready       <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
  end

  // Result side: draw a stall per result, then hold ready until a transfer.
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      stall = sink_idles ? $urandom_range(0, MAX_IDLE) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  always @(posedge clk_i) begin
    soc_pkg::soc_res_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transfer value", out_ch.result_value, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.result_value !== want.result_value)
          report_mismatch("result_value", out_ch.result_value, want.result_value);
        if (out_ch.result_word !== want.result_word)
          report_mismatch("result_word", {32'd0, out_ch.result_word},
                          {32'd0, want.result_word});
        if (out_ch.too_big !== want.too_big)
          report_mismatch("too_big", {63'd0, out_ch.too_big}, {63'd0, want.too_big});
      end
    end
  end

  initial begin
    logic [1:0]  op;
    int unsigned pick;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    foreach (CODEC_ROWS[i]) begin
      send_request(CODEC_ROWS[i].op, CODEC_ROWS[i].value, CODEC_ROWS[i].word,
                   CODEC_ROWS[i].typed, CODEC_ROWS[i].golden);
    end
    in_ch.valid <= 1'b0;
    drain_pending();
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_ITEMS == 0) begin
        case (n / PHASE_ITEMS)
          0: begin
            sender_idles = 1'b0;
            sink_idles   = 1'b0;
          end
          1: begin
            sender_idles = 1'b1;
            sink_idles   = 1'b1;
          end
          default: begin
            sender_idles = 1'($urandom_range(0, 1));
            sink_idles   = 1'($urandom_range(0, 1));
          end
        endcase
        if (n / PHASE_ITEMS == 5) begin
          in_ch.valid <= 1'b0;
          drain_pending();
        end
      end
      pick = $urandom_range(0, 15);
      if (pick < 5) op = soc_pkg::OP_DECODE;
      else if (pick < 10) op = soc_pkg::OP_ENCODE;
      else if (pick < 15) op = soc_pkg::OP_ROUND;
      else op = OP_UNUSED;
      send_request(op, random_offset(), $urandom, 1'b0, NO_RES);
    end
    in_ch.valid <= 1'b0;
    drain_pending();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb_scaled_offset_codec: clean");
    end else begin
      $display("tb_scaled_offset_codec: errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("tb_scaled_offset_codec: errors");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/soc_pkg.sv
hw/rtl/soc_in_if.sv
hw/rtl/soc_out_if.sv
hw/rtl/soc_core.sv
hw/rtl/scaled_offset_codec.sv
bench/tb_scaled_offset_codec.sv
